[rtl/multi_stream_frame_timer_unit_defines.svh]
// assertion macros for the multi-stream frame timer
`ifndef MULTI_STREAM_FRAME_TIMER_UNIT_DEFINES_SVH
`define MULTI_STREAM_FRAME_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define MSFT_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("msft assertion failed");
// condition must never be true outside reset
`define MSFT_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("msft forbidden condition");
`else
`define MSFT_ASSERT(lbl, ck, rn, prop)
`define MSFT_ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

[rtl/msft_pkg.sv]
// shared types, constants and command/status structs of the frame timer
`timescale 1ns / 1ps
package msft_pkg;
	localparam int MAX_STREAMS_DEF    = 8;
	localparam int MAX_FRAMES_DEF     = 64;
	localparam int BACKGROUND_KEY_DEF = 63;

	localparam int KIND_W     = 3;
	localparam int KEY_W      = 6;
	localparam int FC_W       = 7;
	localparam int FNUM_W     = 6;
	localparam int DELAY_W    = 16;
	localparam int ELAPSED_W  = 16;
	localparam int ACC_W      = 32;
	localparam int EV_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [KIND_W-1:0] {
		K_SET_KEY = 3'd0,
		K_SET_BG  = 3'd1,
		K_WRITE   = 3'd2,
		K_REM_KEY = 3'd3,
		K_REM_BG  = 3'd4,
		K_CLOSE   = 3'd5,
		K_TICK    = 3'd6
	} kind_t;

	typedef enum logic [EV_W-1:0] {
		EV_STATUS  = 2'd0,
		EV_FRAME   = 2'd1,
		EV_REMOVED = 2'd2
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_SUP       = 2'd0,
		CFG_BG_SUP        = 2'd1,
		CFG_LOOP          = 2'd2,
		CFG_DEFAULT_DELAY = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EM_STATUS,
		EM_REMOVE_KEY,
		EM_REMOVE_TOP,
		EM_PEND
	} emit_sel_t;

	typedef enum logic [1:0] {
		RD_WALK,
		RD_SLOT,
		RD_TOP
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REMOVE_EV,
		ST_STATUS,
		ST_CLOSE,
		ST_T_READ,
		ST_T_CHECK,
		ST_T_PRES,
		ST_T_END
	} state_t;

	typedef struct packed {
		logic      load;
		rd_sel_t   rd_sel;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_rej;
		logic      emit_last;
		logic      fill;
		logic      drop;
		logic      cnt_dec;
		logic      loop_clr;
		logic      ram_we;
		logic      ram_re;
		logic      ram_next;
		logic      idx_clr;
		logic      idx_inc;
		logic      tick_upd;
		logic      tick_adv;
		logic      pend_load;
		logic      pend_clr;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              found;
		logic              full;
		logic              empty;
		logic              fc_ok;
		logic              wr_ok;
		logic              key_sup;
		logic              bg_sup;
		logic              loop_en;
		logic              adv;
		logic              present;
		logic              last_entry;
		logic              pend_valid;
		logic              out_free;
	} stat_t;
endpackage

[rtl/msft_if.sv]
// input and result channel interfaces
`timescale 1ns / 1ps
interface msft_in_if import msft_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [KEY_W-1:0]     key;
	logic [FC_W-1:0]      num_frames;
	logic [FNUM_W-1:0]    frame_number;
	logic [DELAY_W-1:0]   frame_delay_ms;
	logic                 frame_present;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, kind, key, num_frames, frame_number, frame_delay_ms,
		frame_present, elapsed_ms, input ready);
	modport sink (input valid, kind, key, num_frames, frame_number, frame_delay_ms,
		frame_present, elapsed_ms, output ready);
endinterface

interface msft_out_if import msft_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EV_W-1:0]  event_res;
	logic [KEY_W-1:0] stream_key;
	logic [5:0]       shown_frame;
	logic             status;
	logic             last;

	modport source (output valid, event_res, stream_key, shown_frame, status, last,
		input ready);
	modport sink (input valid, event_res, stream_key, shown_frame, status, last,
		output ready);
endinterface

[rtl/msft_ram.sv]
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module msft_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/msft_ctrl.sv]
// controller state machine of the frame timer
`timescale 1ns / 1ps
module msft_ctrl import msft_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);
	state_t state_q, state_d;
	logic   rej_q, rej_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rej_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rej_q   <= rej_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rej_d    = rej_q;
		cmd      = '0;
		cmd.rd_sel   = RD_WALK;
		cmd.emit_sel = EM_STATUS;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.rd_sel = RD_SLOT;
				rej_d      = 1'b0;
				unique case (kind_t'(st.kind))
					K_SET_KEY, K_SET_BG: begin
						if (!((kind_t'(st.kind) == K_SET_KEY ? st.key_sup : st.bg_sup)
							&& st.fc_ok)) begin
							rej_d   = 1'b1;
							state_d = ST_STATUS;
						end else if (st.found) begin
							state_d = ST_REMOVE_EV;
						end else begin
							// a full table drops the new stream quietly
							cmd.fill = !st.full;
							state_d  = ST_STATUS;
						end
					end
					K_WRITE: begin
						if (st.found && st.wr_ok) begin
							cmd.ram_we = 1'b1;
						end else begin
							rej_d = 1'b1;
						end
						state_d = ST_STATUS;
					end
					K_REM_KEY, K_REM_BG: begin
						if (kind_t'(st.kind) == K_REM_BG && !st.bg_sup) begin
							rej_d   = 1'b1;
							state_d = ST_STATUS;
						end else if (st.found) begin
							state_d = ST_REMOVE_EV;
						end else begin
							state_d = ST_STATUS;
						end
					end
					K_CLOSE: state_d = ST_CLOSE;
					K_TICK: begin
						if (st.loop_en && !st.empty) begin
							cmd.idx_clr = 1'b1;
							state_d     = ST_T_READ;
						end else begin
							state_d = ST_IDLE;
						end
					end
					default: begin
						rej_d   = 1'b1;
						state_d = ST_STATUS;
					end
				endcase
			end
			ST_REMOVE_EV: begin
				cmd.rd_sel = RD_SLOT;
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_REMOVE_KEY;
					if (kind_t'(st.kind) == K_SET_KEY || kind_t'(st.kind) == K_SET_BG) begin
						cmd.fill = 1'b1;
					end else begin
						cmd.drop = 1'b1;
					end
					state_d = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_STATUS;
					cmd.emit_rej  = rej_q;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_CLOSE: begin
				cmd.rd_sel = RD_TOP;
				if (st.empty) begin
					cmd.loop_clr = 1'b1;
					state_d      = ST_STATUS;
				end else if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_REMOVE_TOP;
					cmd.cnt_dec  = 1'b1;
				end
			end
			ST_T_READ: begin
				cmd.tick_upd = 1'b1;
				cmd.ram_re   = 1'b1;
				state_d      = ST_T_CHECK;
			end
			ST_T_CHECK: begin
				if (st.adv) begin
					cmd.tick_adv = 1'b1;
					cmd.ram_re   = 1'b1;
					cmd.ram_next = 1'b1;
					state_d      = ST_T_PRES;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = st.last_entry ? ST_T_END : ST_T_READ;
				end
			end
			ST_T_PRES: begin
				if (!st.present) begin
					cmd.idx_inc = 1'b1;
					state_d     = st.last_entry ? ST_T_END : ST_T_READ;
				end else if (!st.pend_valid || st.out_free) begin
					// the held event goes out as not-last once a newer one exists
					cmd.emit      = st.pend_valid;
					cmd.emit_sel  = EM_PEND;
					cmd.pend_load = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = st.last_entry ? ST_T_END : ST_T_READ;
				end
			end
			ST_T_END: begin
				if (!st.pend_valid) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_PEND;
					cmd.emit_last = 1'b1;
					cmd.pend_clr  = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[rtl/msft_datapath.sv]
// stream table, frame delay store, tick arithmetic and result register
`timescale 1ns / 1ps
module msft_datapath import msft_pkg::*; #(
	parameter int MAX_STREAMS    = MAX_STREAMS_DEF,
	parameter int MAX_FRAMES     = MAX_FRAMES_DEF,
	parameter int BACKGROUND_KEY = BACKGROUND_KEY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 st,
	input  logic [KIND_W-1:0]     in_kind,
	input  logic [KEY_W-1:0]      in_key,
	input  logic [FC_W-1:0]       in_num_frames,
	input  logic [FNUM_W-1:0]     in_frame_number,
	input  logic [DELAY_W-1:0]    in_frame_delay_ms,
	input  logic                  in_frame_present,
	input  logic [ELAPSED_W-1:0]  in_elapsed_ms,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [EV_W-1:0]       out_event_res,
	output logic [KEY_W-1:0]      out_stream_key,
	output logic [5:0]            out_shown_frame,
	output logic                  out_status,
	output logic                  out_last
);
	localparam int ROW_W  = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W  = $clog2(MAX_STREAMS + 1);
	localparam int ADDR_W = ROW_W + FIDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int WORD_W = DELAY_W + 1;

	// configuration
	logic               key_sup_q, bg_sup_q, loop_en_q;
	logic [DELAY_W-1:0] def_delay_q;

	// latched item
	logic [KIND_W-1:0]    kind_q;
	logic [KEY_W-1:0]     key_q;
	logic [FC_W-1:0]      fc_q;
	logic [FNUM_W-1:0]    fnum_q;
	logic [DELAY_W-1:0]   fdelay_q;
	logic                 fpres_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	// stream table
	logic [CNT_W-1:0]  cnt_q;
	logic [KEY_W-1:0]  keys_q [MAX_STREAMS];
	logic [FC_W-1:0]   fcs_q  [MAX_STREAMS];
	logic [FIDX_W-1:0] cur_q  [MAX_STREAMS];
	logic [ACC_W-1:0]  acc_q  [MAX_STREAMS];
	logic [ROW_W-1:0]  map_q  [MAX_STREAMS];
	logic [CNT_W-1:0]  idx_q;

	logic [ACC_W-1:0]  tick_acc_s1;
	logic              pend_valid_q;
	logic [KEY_W-1:0]  pend_key_q;
	logic [5:0]        pend_frame_q;

	logic [MAX_STREAMS-1:0] match;
	logic [ROW_W-1:0]       slot_idx;
	logic                   found;
	logic [ROW_W-1:0]       rd_idx;
	logic [ROW_W-1:0]       walk_idx;
	logic [ROW_W-1:0]       fill_idx;
	logic [ACC_W:0]         sum_wide;
	logic [ACC_W-1:0]       sat_sum;
	logic [DELAY_W-1:0]     delay;
	logic [8:0]             cur_inc;
	logic [FIDX_W-1:0]      cur_next;
	logic                   ge;

	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [WORD_W-1:0]      ram_wdata, ram_rdata;
	logic                   out_free;

	// key lookup over the live entries, lowest slot wins
	always_comb begin
		slot_idx = '0;
		found    = 1'b0;
		for (int i = 0; i < MAX_STREAMS; i++) begin
			match[i] = (CNT_W'(i) < cnt_q) && (keys_q[i] == key_q);
		end
		for (int i = MAX_STREAMS - 1; i >= 0; i--) begin
			if (match[i]) begin
				slot_idx = ROW_W'(i);
				found    = 1'b1;
			end
		end
	end

	assign walk_idx = idx_q[ROW_W-1:0];
	assign fill_idx = found ? slot_idx : cnt_q[ROW_W-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_SLOT: rd_idx = slot_idx;
			RD_TOP:  rd_idx = ROW_W'(cnt_q - CNT_W'(1));
			default: rd_idx = walk_idx;
		endcase
	end

	// tick arithmetic
	assign sum_wide = {1'b0, acc_q[walk_idx]} + (ACC_W + 1)'(elapsed_q);
	assign sat_sum  = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
	assign delay    = (ram_rdata[DELAY_W-1:0] == '0) ? def_delay_q : ram_rdata[DELAY_W-1:0];
	assign ge       = tick_acc_s1 >= ACC_W'(delay);
	assign cur_inc  = 9'(cur_q[walk_idx]) + 9'd1;
	assign cur_next = (cur_inc >= 9'(fcs_q[walk_idx])) ? '0 : FIDX_W'(cur_inc);

	// frame store addressing goes through the slot to row map
	assign ram_we    = cmd.ram_we;
	assign ram_waddr = {map_q[rd_idx], FIDX_W'(fnum_q)};
	assign ram_wdata = {fpres_q, fdelay_q};
	assign ram_raddr = {map_q[walk_idx], cmd.ram_next ? cur_next : cur_q[walk_idx]};

	msft_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free = !out_valid || out_ready;

	always_comb begin
		st            = '0;
		st.kind       = kind_q;
		st.found      = found;
		st.full       = cnt_q == CNT_W'(MAX_STREAMS);
		st.empty      = cnt_q == '0;
		st.fc_ok      = (fc_q != '0) && (9'(fc_q) <= 9'(MAX_FRAMES));
		st.wr_ok      = (9'(fnum_q) < 9'(MAX_FRAMES)) && ({1'b0, fnum_q} < fcs_q[rd_idx]);
		st.key_sup    = key_sup_q;
		st.bg_sup     = bg_sup_q;
		st.loop_en    = loop_en_q;
		st.adv        = ge;
		st.present    = ram_rdata[DELAY_W];
		st.last_entry = (idx_q + CNT_W'(1)) == cnt_q;
		st.pend_valid = pend_valid_q;
		st.out_free   = out_free;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_sup_q    <= 1'b1;
			bg_sup_q     <= 1'b1;
			loop_en_q    <= 1'b0;
			def_delay_q  <= DELAY_W'(100);
			cnt_q        <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid    <= 1'b0;
			for (int i = 0; i < MAX_STREAMS; i++) begin
				map_q[i] <= ROW_W'(i);
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_KEY_SUP:       key_sup_q   <= cfg_data[0];
					CFG_BG_SUP:        bg_sup_q    <= cfg_data[0];
					CFG_LOOP:          loop_en_q   <= cfg_data[0];
					CFG_DEFAULT_DELAY: def_delay_q <= cfg_data[DELAY_W-1:0];
				endcase
			end else if (cmd.loop_clr) begin
				loop_en_q <= 1'b0;
			end

			if (cmd.fill && !found) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.drop || cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end

			// freed row moves to the end of the live map, keeping it a permutation
			if (cmd.drop) begin
				for (int j = 0; j < MAX_STREAMS - 1; j++) begin
					if (ROW_W'(j) >= slot_idx && CNT_W'(j + 1) < cnt_q) begin
						map_q[j] <= map_q[j+1];
					end
				end
				map_q[ROW_W'(cnt_q - CNT_W'(1))] <= map_q[slot_idx];
			end

			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end

			if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.pend_clr) begin
				pend_valid_q <= 1'b0;
			end

			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= in_kind;
			fc_q      <= in_num_frames;
			fnum_q    <= in_frame_number;
			fdelay_q  <= in_frame_delay_ms;
			fpres_q   <= in_frame_present;
			elapsed_q <= in_elapsed_ms;
			unique case (kind_t'(in_kind))
				K_SET_BG, K_REM_BG: key_q <= KEY_W'(BACKGROUND_KEY);
				K_SET_KEY, K_WRITE, K_REM_KEY, K_TICK: key_q <= in_key;
				default: key_q <= '0;
			endcase
		end

		if (cmd.fill) begin
			keys_q[fill_idx] <= key_q;
			fcs_q[fill_idx]  <= fc_q;
			cur_q[fill_idx]  <= FIDX_W'(fc_q - FC_W'(1));
			acc_q[fill_idx]  <= '0;
		end

		if (cmd.drop) begin
			for (int j = 0; j < MAX_STREAMS - 1; j++) begin
				if (ROW_W'(j) >= slot_idx && CNT_W'(j + 1) < cnt_q) begin
					keys_q[j] <= keys_q[j+1];
					fcs_q[j]  <= fcs_q[j+1];
					cur_q[j]  <= cur_q[j+1];
					acc_q[j]  <= acc_q[j+1];
				end
			end
		end

		if (cmd.tick_upd) begin
			acc_q[walk_idx] <= sat_sum;
			tick_acc_s1     <= sat_sum;
		end
		if (cmd.tick_adv) begin
			acc_q[walk_idx] <= tick_acc_s1 - ACC_W'(delay);
			cur_q[walk_idx] <= cur_next;
		end

		if (cmd.pend_load) begin
			pend_key_q   <= keys_q[walk_idx];
			pend_frame_q <= 6'(cur_q[walk_idx]);
		end

		if (cmd.emit) begin
			out_status <= cmd.emit_rej;
			out_last   <= cmd.emit_last;
			unique case (cmd.emit_sel)
				EM_STATUS: begin
					out_event_res   <= EV_STATUS;
					out_stream_key  <= key_q;
					out_shown_frame <= '0;
				end
				EM_REMOVE_KEY: begin
					out_event_res   <= EV_REMOVED;
					out_stream_key  <= key_q;
					out_shown_frame <= '0;
				end
				EM_REMOVE_TOP: begin
					out_event_res   <= EV_REMOVED;
					out_stream_key  <= keys_q[rd_idx];
					out_shown_frame <= '0;
				end
				EM_PEND: begin
					out_event_res   <= EV_FRAME;
					out_stream_key  <= pend_key_q;
					out_shown_frame <= pend_frame_q;
				end
			endcase
		end
	end
endmodule

[rtl/multi_stream_frame_timer_unit.sv]
// top level of the multi-stream frame timer
// one item at a time: each command but a tick ends in a status item, a close first emits
// one removal per stream, and a tick walks the table (nothing with loop off or an empty table)
// an advancing stream reads the single frame store port twice, one read per cycle
// output stalls hold the controller; the input is ready only when idle
// asynchronous active-low reset empties the table and loads the register
// defaults; the frame store is not cleared, unwritten frames read undefined
`timescale 1ns / 1ps
`include "multi_stream_frame_timer_unit_defines.svh"
module multi_stream_frame_timer_unit import msft_pkg::*; #(
	parameter int MAX_STREAMS    = MAX_STREAMS_DEF,
	parameter int MAX_FRAMES     = MAX_FRAMES_DEF,
	parameter int BACKGROUND_KEY = BACKGROUND_KEY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	msft_in_if.sink               in_ch,
	msft_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	// commands from the controller, status back from the datapath
	cmd_t  cmd;
	stat_t st;

	msft_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.st      (st),
		.cmd     (cmd)
	);

	// table, frame store behind a slot to row map, and the result register
	msft_datapath #(
		.MAX_STREAMS   (MAX_STREAMS),
		.MAX_FRAMES    (MAX_FRAMES),
		.BACKGROUND_KEY(BACKGROUND_KEY)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.in_kind          (in_ch.kind),
		.in_key           (in_ch.key),
		.in_num_frames    (in_ch.num_frames),
		.in_frame_number  (in_ch.frame_number),
		.in_frame_delay_ms(in_ch.frame_delay_ms),
		.in_frame_present (in_ch.frame_present),
		.in_elapsed_ms    (in_ch.elapsed_ms),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_event_res    (out_ch.event_res),
		.out_stream_key   (out_ch.stream_key),
		.out_shown_frame  (out_ch.shown_frame),
		.out_status       (out_ch.status),
		.out_last         (out_ch.last)
	);

	// a new result never overwrites one still waiting
	`MSFT_ASSERT(a_emit_free, clk, arst_n, cmd.emit |-> st.out_free)
	// appends only go into a table with room
	`MSFT_ASSERT_NEVER(a_no_full_append, clk, arst_n, cmd.fill && st.full && !st.found)
	// frame writes only land in a live stream
	`MSFT_ASSERT(a_write_live, clk, arst_n, cmd.ram_we |-> st.found)
	// one item in flight at a time
	`MSFT_ASSERT(a_one_item, clk, arst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
endmodule

[tb/msft_checker.sv]
// checker for the frame timer: mirrors the stream table, predicts results and compares them
`timescale 1ns / 1ps
module msft_checker import msft_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	msft_in_if                    in_mon,
	msft_out_if                   out_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);
	localparam int NSTR  = MAX_STREAMS_DEF;
	localparam int NFRM  = MAX_FRAMES_DEF;
	localparam int BGKEY = BACKGROUND_KEY_DEF;

	typedef struct {
		ev_t        ev;
		logic [5:0] key;
		logic [5:0] frame;
		logic       st;
		logic       last;
	} timer_result_t;

	timer_result_t due_results[$];

	logic        key_sup, bg_sup, loop_on;
	logic [15:0] dflt_delay;
	int          n_streams;
	logic [5:0]  s_key   [NSTR];
	logic [6:0]  s_fc    [NSTR];
	logic [5:0]  s_cur   [NSTR];
	logic [31:0] s_acc   [NSTR];
	logic [16:0] s_frames[NSTR][NFRM];

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic push(ev_t ev, logic [5:0] k, logic [5:0] f, logic st, logic last);
		timer_result_t r;
		r.ev = ev; r.key = k; r.frame = f; r.st = st; r.last = last;
		due_results.push_back(r);
	endtask

	function automatic int find_slot(logic [5:0] k);
		for (int i = 0; i < n_streams; i++)
			if (s_key[i] == k) return i;
		return -1;
	endfunction

	task automatic fill_slot(int s, logic [5:0] k, logic [6:0] fc);
		s_key[s] = k;
		s_fc[s]  = fc;
		s_cur[s] = 6'(fc - 7'd1);
		s_acc[s] = '0;
		for (int f = 0; f < NFRM; f++) s_frames[s][f] = '0;
	endtask

	task automatic drop_slot(int s);
		for (int j = s + 1; j < n_streams; j++) begin
			s_key[j-1] = s_key[j];
			s_fc[j-1]  = s_fc[j];
			s_cur[j-1] = s_cur[j];
			s_acc[j-1] = s_acc[j];
			for (int f = 0; f < NFRM; f++) s_frames[j-1][f] = s_frames[j][f];
		end
		n_streams--;
	endtask

	task automatic set_stream(logic [5:0] k, logic [6:0] fc, logic ok);
		int s;
		if (!ok || fc == 0 || fc > NFRM) begin
			push(EV_STATUS, k, 6'd0, 1'b1, 1'b1);
			return;
		end
		s = find_slot(k);
		if (s >= 0) begin
			push(EV_REMOVED, k, 6'd0, 1'b0, 1'b0);
			fill_slot(s, k, fc);
		end else if (n_streams < NSTR) begin
			fill_slot(n_streams, k, fc);
			n_streams++;
		end
		push(EV_STATUS, k, 6'd0, 1'b0, 1'b1);
	endtask

	task automatic unset_stream(logic [5:0] k);
		int s;
		s = find_slot(k);
		if (s >= 0) begin
			push(EV_REMOVED, k, 6'd0, 1'b0, 1'b0);
			drop_slot(s);
		end
		push(EV_STATUS, k, 6'd0, 1'b0, 1'b1);
	endtask

	task automatic advance_streams(logic [15:0] el);
		int          shown;
		logic [32:0] sum;
		logic [15:0] d;
		if (!loop_on || n_streams == 0) return;
		shown = 0;
		for (int i = 0; i < n_streams; i++) begin
			if (s_fc[i] == 0 || s_fc[i] > NFRM || s_cur[i] >= s_fc[i]) continue;
			sum = {1'b0, s_acc[i]} + el;
			s_acc[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			d = s_frames[i][s_cur[i]][15:0];
			if (d == 0) d = dflt_delay;
			if (s_acc[i] < d) continue;
			s_acc[i] = s_acc[i] - d;
			s_cur[i] = (int'(s_cur[i]) + 1 >= int'(s_fc[i])) ? 6'd0 : s_cur[i] + 6'd1;
			if (!s_frames[i][s_cur[i]][16]) continue;
			push(EV_FRAME, s_key[i], s_cur[i], 1'b0, 1'b0);
			shown++;
		end
		// last frame event of the tick asks for a refresh
		if (shown > 0) due_results[due_results.size()-1].last = 1'b1;
	endtask

	task automatic predict_item();
		int s;
		case (in_mon.kind)
			K_SET_KEY: set_stream(in_mon.key, in_mon.num_frames, key_sup);
			K_SET_BG:  set_stream(6'(BGKEY), in_mon.num_frames, bg_sup);
			K_WRITE: begin
				s = find_slot(in_mon.key);
				if (s < 0 || in_mon.frame_number >= s_fc[s]) begin
					push(EV_STATUS, in_mon.key, 6'd0, 1'b1, 1'b1);
				end else begin
					s_frames[s][in_mon.frame_number] = {in_mon.frame_present, in_mon.frame_delay_ms};
					push(EV_STATUS, in_mon.key, 6'd0, 1'b0, 1'b1);
				end
			end
			K_REM_KEY: unset_stream(in_mon.key);
			K_REM_BG: begin
				if (!bg_sup) push(EV_STATUS, 6'(BGKEY), 6'd0, 1'b1, 1'b1);
				else unset_stream(6'(BGKEY));
			end
			K_CLOSE: begin
				// removals go out from the last entry to the first
				while (n_streams > 0) begin
					push(EV_REMOVED, s_key[n_streams-1], 6'd0, 1'b0, 1'b0);
					n_streams--;
				end
				loop_on = 1'b0;
				push(EV_STATUS, 6'd0, 6'd0, 1'b0, 1'b1);
			end
			K_TICK: advance_streams(in_mon.elapsed_ms);
			default: push(EV_STATUS, 6'd0, 6'd0, 1'b1, 1'b1);
		endcase
	endtask

	task automatic check_result();
		timer_result_t w;
		if (due_results.size() == 0) begin
			report_mismatch("unexpected item, event", int'(out_mon.event_res), -1);
			return;
		end
		w = due_results.pop_front();
		if (out_mon.event_res !== w.ev) report_mismatch("event_res", out_mon.event_res, w.ev);
		if (out_mon.stream_key !== w.key) report_mismatch("stream_key", out_mon.stream_key, w.key);
		if (out_mon.shown_frame !== w.frame)
			report_mismatch("shown_frame", out_mon.shown_frame, w.frame);
		if (out_mon.status !== w.st) report_mismatch("status", out_mon.status, w.st);
		if (out_mon.last !== w.last) report_mismatch("last", out_mon.last, w.last);
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_sup    = 1'b1;
			bg_sup     = 1'b1;
			loop_on    = 1'b0;
			dflt_delay = 16'd100;
			n_streams  = 0;
			due_results.delete();
			pending    = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) check_result();
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_SUP:       key_sup = cfg_data[0];
					CFG_BG_SUP:        bg_sup = cfg_data[0];
					CFG_LOOP:          loop_on = cfg_data[0];
					CFG_DEFAULT_DELAY: dflt_delay = cfg_data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) predict_item();
			pending = due_results.size();
		end
	end
endmodule

[tb/multi_stream_frame_timer_unit_tb.sv]
// top of the frame timer testbench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps
module multi_stream_frame_timer_unit_tb;
	import msft_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int RANDOM_ITEMS   = 450;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending;
	int                    items_sent = 0;
	int                    idle_cycles = 0;
	int                    stall_left = 0;
	// no gaps and no stalls while set
	logic                  calm = 1'b0;

	msft_in_if  in_ch ();
	msft_out_if out_ch ();

	multi_stream_frame_timer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	msft_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid          = 1'b0;
		in_ch.kind           = '0;
		in_ch.key            = '0;
		in_ch.num_frames     = '0;
		in_ch.frame_number   = '0;
		in_ch.frame_delay_ms = '0;
		in_ch.frame_present  = 1'b0;
		in_ch.elapsed_ms     = '0;
	end

	// result side: a fresh random stall after every accepted result item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left = 0;
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) stall_left = calm ? 0 : $urandom_range(0, 3);
			else if (stall_left > 0) stall_left--;
			out_ch.ready <= (stall_left == 0);
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** multi_stream_frame_timer_unit: FAILED **");
				$finish;
			end
		end
	end

	// drive one item, wait for its handshake, then the gap before the next one
	task automatic send_item(logic [2:0] kind, logic [5:0] key, logic [6:0] fc, logic [5:0] fnum,
		logic [15:0] fdelay, logic fpres, logic [15:0] elapsed);
		int gap;
		in_ch.kind           <= kind;
		in_ch.key            <= key;
		in_ch.num_frames     <= fc;
		in_ch.frame_number   <= fnum;
		in_ch.frame_delay_ms <= fdelay;
		in_ch.frame_present  <= fpres;
		in_ch.elapsed_ms     <= elapsed;
		in_ch.valid          <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// unused fields carry random values so every bit moves
	task automatic send_cmd(logic [2:0] kind, logic [5:0] key, logic [6:0] fc);
		send_item(kind, key, fc, 6'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
	endtask

	task automatic send_tick(logic [15:0] elapsed);
		send_item(K_TICK, 6'($urandom), 7'($urandom), 6'($urandom), 16'($urandom), 1'($urandom),
			elapsed);
	endtask

	task automatic send_write(logic [5:0] key, logic [5:0] fnum, logic [15:0] fdelay, logic fpres);
		send_item(K_WRITE, key, 7'($urandom), fnum, fdelay, fpres, 16'($urandom));
	endtask

	// drains the block so that a register write finds it idle
	task automatic wait_quiet();
		@(posedge clk);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// set a stream, then load every frame so no tick reads an unwritten frame
	task automatic open_stream(logic bg, logic [5:0] key, logic [6:0] fc, logic long_delays);
		logic [15:0] d;
		send_cmd(bg ? K_SET_BG : K_SET_KEY, key, fc);
		for (int f = 0; f < fc; f++) begin
			d = long_delays ? 16'($urandom) : 16'($urandom_range(0, 30));
			send_write(bg ? 6'(BACKGROUND_KEY_DEF) : key, 6'(f), d, $urandom_range(0, 9) < 7);
		end
	endtask

	function automatic logic [5:0] pick_key();
		return ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
	endfunction

	initial begin
		int          r;
		int          phase_items;
		logic [15:0] dly;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table and rejected commands
		send_cmd(K_CLOSE, 6'd0, 7'd0);
		send_cmd(3'd7, 6'd5, 7'd1);
		send_cmd(K_SET_KEY, 6'd1, 7'd0);
		send_cmd(K_SET_KEY, 6'd1, 7'd127);
		send_cmd(K_SET_KEY, 6'd1, 7'd65);
		send_write(6'd9, 6'd0, 16'hFFFF, 1'b1);
		send_cmd(K_REM_KEY, 6'd9, 7'd3);
		// loop is off after reset, so the tick does nothing
		send_tick(16'hFFFF);
		// background key through a key set, then a background set replaces it
		open_stream(1'b0, 6'd63, 7'd1, 1'b0);
		open_stream(1'b1, 6'd0, 7'd2, 1'b0);
		send_write(6'd63, 6'd2, 16'd7, 1'b1);
		open_stream(1'b0, 6'd0, 7'd1, 1'b0);
		send_cmd(K_REM_KEY, 6'd0, 7'd1);
		send_cmd(K_REM_BG, 6'd0, 7'd1);
		wait_quiet();
		write_reg(CFG_KEY_SUP, 16'd0);
		write_reg(CFG_BG_SUP, 16'd0);
		send_cmd(K_SET_KEY, 6'd3, 7'd2);
		send_cmd(K_SET_BG, 6'd3, 7'd2);
		send_cmd(K_REM_BG, 6'd3, 7'd2);
		wait_quiet();
		write_reg(CFG_KEY_SUP, 16'd1);
		write_reg(CFG_BG_SUP, 16'd1);
		write_reg(CFG_DEFAULT_DELAY, 16'd1);
		write_reg(CFG_LOOP, 16'd1);

		// random phases of stream setup, ticks and noise
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			phase_items = 0;
			while (phase_items < 60 && items_sent < RANDOM_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 28) begin
					open_stream($urandom_range(0, 7) == 0, pick_key(),
						($urandom_range(0, 40) == 0) ? 7'd64 : 7'($urandom_range(1, 4)),
						$urandom_range(0, 9) == 0);
				end else if (r < 72) begin
					send_tick(($urandom_range(0, 9) == 0) ? 16'($urandom) :
						16'($urandom_range(0, 30)));
				end else if (r < 80) begin
					send_write(pick_key(), 6'($urandom_range(0, 5)), 16'($urandom), 1'($urandom));
				end else if (r < 87) begin
					send_cmd(K_REM_KEY, pick_key(), 7'($urandom));
				end else if (r < 90) begin
					send_cmd(K_REM_BG, 6'($urandom), 7'($urandom));
				end else if (r < 93) begin
					send_cmd(K_CLOSE, 6'($urandom), 7'($urandom));
				end else if (r < 97) begin
					send_cmd($urandom_range(0, 1) ? K_SET_KEY : K_SET_BG, pick_key(),
						$urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127)));
				end else begin
					send_cmd(3'd7, 6'($urandom), 7'($urandom));
				end
				phase_items++;
			end
			wait_quiet();
			// new phase: delay setting, support bits, and a loop setting that is mostly on again after a close
			case ($urandom_range(0, 5))
				0: dly = 16'd1;
				1: dly = 16'hFFFF;
				default: dly = 16'($urandom_range(2, 20));
			endcase
			write_reg(CFG_DEFAULT_DELAY, dly);
			write_reg(CFG_KEY_SUP, 16'($urandom_range(0, 7) != 0));
			write_reg(CFG_BG_SUP, 16'($urandom_range(0, 7) != 0));
			write_reg(CFG_LOOP, 16'($urandom_range(0, 9) != 0));
			calm <= ($urandom_range(0, 3) == 0);
		end

		wait_quiet();
		if (fail_count == 0) begin
			$display("** multi_stream_frame_timer_unit: PASSED **");
		end else begin
			$display("** multi_stream_frame_timer_unit: FAILED **");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/msft_pkg.sv
rtl/msft_if.sv
rtl/msft_ram.sv
rtl/msft_ctrl.sv
rtl/msft_datapath.sv
rtl/multi_stream_frame_timer_unit.sv
tb/msft_checker.sv
tb/multi_stream_frame_timer_unit_tb.sv
